// File: design/sbbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbbm_pkg
// Shared types, sizes and register codes of the sample block buffer manager.
// ----------------------------------------------------------------------------
package sbbm_pkg;

   localparam int BUFFER_COUNT     = 10;
   localparam int SLOTS_PER_BUFFER = 32;
   localparam int RING_DEPTH       = BUFFER_COUNT + 1;

   typedef logic [3:0]  buf_type;     // buffer index, fixed by the result fields
   typedef logic [3:0]  count_type;   // free count, 0 .. BUFFER_COUNT
   typedef logic [3:0]  ptr_type;     // full ring pointer, 0 .. RING_DEPTH-1
   typedef logic [7:0]  slot_type;    // slot within a buffer
   typedef logic [31:0] word_type;

   localparam count_type BUF_TOTAL  = count_type'(BUFFER_COUNT);
   localparam slot_type  SLOT_TOTAL = slot_type'(SLOTS_PER_BUFFER);
   localparam ptr_type   RING_LAST  = ptr_type'(RING_DEPTH - 1);

   localparam word_type FILE_LIMIT_RESET = 32'd65536;
   localparam word_type COUNT_MAX        = 32'hFFFF_FFFF;

   // register indexes on the control port
   localparam logic CSR_MAX_BLOCKS = 1'b0;
   localparam logic CSR_FILE_LIMIT = 1'b1;

   function automatic ptr_type ring_next(input ptr_type p);
      ring_next = (p == RING_LAST) ? '0 : ptr_type'(p + 4'd1);
   endfunction

endpackage
`default_nettype wire

// File: design/sample_block_buffer_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_block_buffer_manager
// Buffer pool for a sampling front end: free stack, open buffer, full ring.
//
// Each req_ transfer is one sample period carrying req_card_busy. The block
// pops a free buffer when none is open, places the sample into the next slot
// (or counts an overrun), moves a filled buffer into the full ring and, when
// the card is idle, hands the oldest full buffer to the card and returns it
// to the free stack. Every request yields exactly one rsp_ transfer.
// The result register is loaded at the edge that accepts the request.
// Throughput: one request per cycle, the whole update is one pass of
// logic between the state registers and the result register.
// When the receiver stalls, the result register holds and req_stall is
// raised, so no request is taken until the result has gone.
// Reset clears the pool (stack holds buffers 0..9), counters and flags;
// max_blocks resets to 0 (no limit), file_block_limit to 65536.
// Once a block limit is reached, further requests leave all state alone.
// Registers: 0x0 max_blocks, 0x4 file_block_limit; write only while idle.
// ----------------------------------------------------------------------------
module sample_block_buffer_manager (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   // request channel
   input  wire  logic                 req_valid,
   output       logic                 req_stall,
   input  wire  logic                 req_card_busy,
   // result channel
   output       logic                 rsp_valid,
   input  wire  logic                 rsp_stall,
   output       logic                 rsp_sample_taken,
   output       sbbm_pkg::buf_type    rsp_sample_buffer,
   output       sbbm_pkg::slot_type   rsp_sample_slot,
   output       logic                 rsp_overrun,
   output       logic                 rsp_write_issued,
   output       sbbm_pkg::buf_type    rsp_write_buffer,
   output       sbbm_pkg::word_type   rsp_blocks_written,
   output       logic                 rsp_recording_done,
   output       sbbm_pkg::count_type  rsp_fewest_free,
   output       sbbm_pkg::word_type   rsp_overrun_count,
   // control port
   input  wire  logic                 csr_psel,
   input  wire  logic                 csr_penable,
   input  wire  logic                 csr_pwrite,
   input  wire  logic [2:0]           csr_paddr,
   input  wire  sbbm_pkg::word_type   csr_pwdata,
   output       sbbm_pkg::word_type   csr_prdata,
   output       logic                 csr_pready
);

   // -------------------------------------------------------------------------
   // Control registers
   // -------------------------------------------------------------------------
   sbbm_pkg::word_type max_blocks_ff;
   sbbm_pkg::word_type file_limit_ff;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_blocks_ff <= '0;
         file_limit_ff <= sbbm_pkg::FILE_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            sbbm_pkg::CSR_MAX_BLOCKS: max_blocks_ff <= csr_pwdata;
            sbbm_pkg::CSR_FILE_LIMIT: file_limit_ff <= csr_pwdata;
            default:                  max_blocks_ff <= max_blocks_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sbbm_pkg::CSR_MAX_BLOCKS: csr_prdata = max_blocks_ff;
         sbbm_pkg::CSR_FILE_LIMIT: csr_prdata = file_limit_ff;
         default:                  csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Pool state
   // -------------------------------------------------------------------------
   sbbm_pkg::buf_type   free_stack_ff [sbbm_pkg::BUFFER_COUNT];
   sbbm_pkg::buf_type   full_ring_ff  [sbbm_pkg::RING_DEPTH];
   sbbm_pkg::count_type free_count_ff, free_count_in;
   logic                holding_ff,    holding_in;
   sbbm_pkg::buf_type   open_buf_ff,   open_buf_in;
   sbbm_pkg::slot_type  fill_ff,       fill_in;
   sbbm_pkg::ptr_type   head_ff,       head_in;
   sbbm_pkg::ptr_type   tail_ff,       tail_in;
   sbbm_pkg::word_type  written_ff,    written_in;
   sbbm_pkg::word_type  overruns_ff,   overruns_in;
   sbbm_pkg::count_type lowest_ff,     lowest_in;
   logic                finished_ff,   finished_in;

   // result register
   logic                rsp_valid_ff;
   logic                taken_ff;
   sbbm_pkg::buf_type   sbuf_ff;
   sbbm_pkg::slot_type  sslot_ff;
   logic                ovr_ff;
   logic                wr_ff;
   sbbm_pkg::buf_type   wbuf_ff;

   logic accept;
   logic active;

   // Take a request whenever the result register is empty or draining.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign active    = accept & ~finished_ff;

   // -------------------------------------------------------------------------
   // One-pass update
   // -------------------------------------------------------------------------
   logic                pop_free;
   sbbm_pkg::count_type count_dec;
   sbbm_pkg::count_type count_a;
   sbbm_pkg::buf_type   open_a;
   logic                hold_a;
   sbbm_pkg::slot_type  fill_a;
   sbbm_pkg::slot_type  fill_inc;
   logic                buf_full;
   sbbm_pkg::ptr_type   head_nxt;
   logic                ring_push;
   sbbm_pkg::ptr_type   head_b;
   logic                ring_pop;
   sbbm_pkg::buf_type   pop_buf;
   logic                stack_push;
   sbbm_pkg::word_type  written_inc;
   logic                limit_hit;

   always_comb begin
      // open a buffer from the free stack if none is held
      pop_free  = ~holding_ff & (free_count_ff != '0);
      count_dec = free_count_ff - 4'd1;
      if (count_dec >= sbbm_pkg::BUF_TOTAL) begin
         count_dec = '0;
      end
      count_a = pop_free ? count_dec : free_count_ff;
      open_a  = pop_free ? free_stack_ff[count_dec] : open_buf_ff;
      hold_a  = holding_ff | pop_free;
      fill_a  = pop_free ? '0 : fill_ff;

      // place the sample, retire a filled buffer into the ring
      fill_inc  = fill_a + 8'd1;
      buf_full  = hold_a & (fill_inc >= sbbm_pkg::SLOT_TOTAL);
      head_nxt  = sbbm_pkg::ring_next(head_ff);
      ring_push = buf_full & (head_nxt != tail_ff);
      head_b    = ring_push ? head_nxt : head_ff;

      // hand the oldest full buffer to the card; bypass a same-period push
      ring_pop   = (head_b != tail_ff) & ~req_card_busy;
      pop_buf    = (ring_push && head_ff == tail_ff) ? open_a : full_ring_ff[tail_ff];
      stack_push = ring_pop & (count_a < sbbm_pkg::BUF_TOTAL);

      written_inc = written_ff + 32'd1;
      limit_hit   = ((file_limit_ff != '0) && (written_inc == file_limit_ff)) ||
                    ((max_blocks_ff != '0) && (written_inc == max_blocks_ff));

      // next state
      free_count_in = stack_push ? count_a + 4'd1 : count_a;
      holding_in    = hold_a & ~buf_full;
      open_buf_in   = open_a;
      fill_in       = hold_a ? fill_inc : fill_a;
      head_in       = head_b;
      tail_in       = ring_pop ? sbbm_pkg::ring_next(tail_ff) : tail_ff;
      written_in    = ring_pop ? written_inc : written_ff;
      finished_in   = ring_pop & limit_hit;
      lowest_in     = (pop_free && count_dec < lowest_ff) ? count_dec : lowest_ff;
      overruns_in   = (~hold_a && overruns_ff != sbbm_pkg::COUNT_MAX) ?
                      overruns_ff + 32'd1 : overruns_ff;
   end

   // -------------------------------------------------------------------------
   // State and result registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbbm_pkg::BUFFER_COUNT; i++) begin
            free_stack_ff[i] <= sbbm_pkg::buf_type'(i);
         end
         free_count_ff <= sbbm_pkg::BUF_TOTAL;
         holding_ff    <= 1'b0;
         open_buf_ff   <= '0;
         fill_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         written_ff    <= '0;
         overruns_ff   <= '0;
         lowest_ff     <= sbbm_pkg::BUF_TOTAL;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (active) begin
            if (stack_push) begin
               free_stack_ff[count_a] <= pop_buf;
            end
            free_count_ff <= free_count_in;
            holding_ff    <= holding_in;
            open_buf_ff   <= open_buf_in;
            fill_ff       <= fill_in;
            head_ff       <= head_in;
            tail_ff       <= tail_in;
            written_ff    <= written_in;
            overruns_ff   <= overruns_in;
            lowest_ff     <= lowest_in;
            finished_ff   <= finished_in;
         end
         // load on accept, drop once the receiver has taken the result
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // filled buffers: written before they are ever read, so no reset
   always_ff @(posedge clock) begin
      if (active && ring_push) begin
         full_ring_ff[head_ff] <= open_a;
      end
   end

   // result payload: event flags are zero after recording has finished
   always_ff @(posedge clock) begin
      if (accept) begin
         taken_ff <= active & hold_a;
         sbuf_ff  <= (active && hold_a) ? open_a : '0;
         sslot_ff <= (active && hold_a) ? fill_a : '0;
         ovr_ff   <= active & ~hold_a;
         wr_ff    <= active & ring_pop;
         wbuf_ff  <= (active && ring_pop) ? pop_buf : '0;
      end
   end

   // counters report straight from state, which only moves on accept
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_taken   = taken_ff;
   assign rsp_sample_buffer  = sbuf_ff;
   assign rsp_sample_slot    = sslot_ff;
   assign rsp_overrun        = ovr_ff;
   assign rsp_write_issued   = wr_ff;
   assign rsp_write_buffer   = wbuf_ff;
   assign rsp_blocks_written = written_ff;
   assign rsp_recording_done = finished_ff;
   assign rsp_fewest_free    = lowest_ff;
   assign rsp_overrun_count  = overruns_ff;

endmodule
`default_nettype wire

// File: dv/sbbm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbbm_checker
// Watches the request, result and register ports of the buffer manager,
// predicts the result of every accepted sample period from a private copy of
// the pool state, and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
module sbbm_checker
   import sbbm_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   input  wire  logic        req_stall,
   input  wire  logic        req_card_busy,
   input  wire  logic        rsp_valid,
   input  wire  logic        rsp_stall,
   input  wire  logic        rsp_sample_taken,
   input  wire  buf_type     rsp_sample_buffer,
   input  wire  slot_type    rsp_sample_slot,
   input  wire  logic        rsp_overrun,
   input  wire  logic        rsp_write_issued,
   input  wire  buf_type     rsp_write_buffer,
   input  wire  word_type    rsp_blocks_written,
   input  wire  logic        rsp_recording_done,
   input  wire  count_type   rsp_fewest_free,
   input  wire  word_type    rsp_overrun_count,
   input  wire  logic        csr_psel,
   input  wire  logic        csr_penable,
   input  wire  logic        csr_pwrite,
   input  wire  logic [2:0]  csr_paddr,
   input  wire  word_type    csr_pwdata,
   input  wire  word_type    csr_prdata,
   input  wire  logic        csr_pready,
   output       int          error_count,
   output       int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic      sample_taken;
      buf_type   sample_buffer;
      slot_type  sample_slot;
      logic      overrun;
      logic      write_issued;
      buf_type   write_buffer;
      word_type  blocks_written;
      logic      recording_done;
      count_type fewest_free;
      word_type  overrun_count;
   } period_result_type;

   // private copy of the pool
   buf_type   free_bufs [BUFFER_COUNT];
   count_type free_left;
   logic      have_open;
   buf_type   open_idx;
   slot_type  fill_level;
   buf_type   full_bufs [RING_DEPTH];
   ptr_type   full_head;
   ptr_type   full_tail;
   word_type  blocks_out;
   word_type  dropped;
   count_type low_water;
   logic      stopped;
   word_type  blocks_wanted;
   word_type  file_capacity;

   period_result_type due_results [$];

   function automatic ptr_type step_ptr(input ptr_type p);
      if (p == ptr_type'(RING_DEPTH - 1)) return '0;
      return p + 4'd1;
   endfunction

   task automatic clear_pool();
      for (int i = 0; i < BUFFER_COUNT; i++) free_bufs[i] = buf_type'(i);
      free_left     = BUF_TOTAL;
      have_open     = 1'b0;
      open_idx      = '0;
      fill_level    = '0;
      full_head     = '0;
      full_tail     = '0;
      blocks_out    = '0;
      dropped       = '0;
      low_water     = BUF_TOTAL;
      stopped       = 1'b0;
      blocks_wanted = '0;
      file_capacity = FILE_LIMIT_RESET;
   endtask

   task automatic advance_period(input logic busy, output period_result_type r);
      buf_type done_buf;
      ptr_type next_head;
      r = '0;
      if (!stopped) begin
         // open a fresh buffer if none is held
         if (!have_open && free_left != '0) begin
            free_left  = free_left - 4'd1;
            open_idx   = free_bufs[free_left];
            have_open  = 1'b1;
            fill_level = '0;
            if (free_left < low_water) low_water = free_left;
         end
         if (!have_open) begin
            r.overrun = 1'b1;
            if (dropped != COUNT_MAX) dropped = dropped + 32'd1;
         end else begin
            r.sample_taken  = 1'b1;
            r.sample_buffer = open_idx;
            r.sample_slot   = fill_level;
            fill_level      = fill_level + 8'd1;
            if (fill_level >= SLOT_TOTAL) begin
               next_head = step_ptr(full_head);
               if (next_head != full_tail) begin
                  full_bufs[full_head] = open_idx;
                  full_head = next_head;
               end
               have_open = 1'b0;
            end
         end
         // hand the oldest full buffer to the card
         if (full_head != full_tail && !busy) begin
            done_buf       = full_bufs[full_tail];
            full_tail      = step_ptr(full_tail);
            r.write_issued = 1'b1;
            r.write_buffer = done_buf;
            if (free_left < BUF_TOTAL) begin
               free_bufs[free_left] = done_buf;
               free_left = free_left + 4'd1;
            end
            blocks_out = blocks_out + 32'd1;
            if ((file_capacity != '0 && blocks_out == file_capacity) ||
                (blocks_wanted != '0 && blocks_out == blocks_wanted))
               stopped = 1'b1;
         end
      end
      r.blocks_written = blocks_out;
      r.recording_done = stopped;
      r.fewest_free    = low_water;
      r.overrun_count  = dropped;
   endtask

   task automatic compare_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count = error_count + 1;
      end
   endtask

   initial error_count = 0;
   initial outstanding = 0;

   always @(posedge clock) begin : watch
      period_result_type want;
      period_result_type seen;
      if (reset) begin
         clear_pool();
         due_results.delete();
      end else begin
         // result side first: it always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_sample_taken, rsp_sample_buffer, rsp_sample_slot, rsp_overrun,
                     rsp_write_issued, rsp_write_buffer, rsp_blocks_written,
                     rsp_recording_done, rsp_fewest_free, rsp_overrun_count};
            if (due_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               error_count = error_count + 1;
            end else begin
               want = due_results.pop_front();
               compare_field("sample_taken",   word_type'(want.sample_taken),
                             word_type'(seen.sample_taken));
               compare_field("sample_buffer",  word_type'(want.sample_buffer),
                             word_type'(seen.sample_buffer));
               compare_field("sample_slot",    word_type'(want.sample_slot),
                             word_type'(seen.sample_slot));
               compare_field("overrun",        word_type'(want.overrun),
                             word_type'(seen.overrun));
               compare_field("write_issued",   word_type'(want.write_issued),
                             word_type'(seen.write_issued));
               compare_field("write_buffer",   word_type'(want.write_buffer),
                             word_type'(seen.write_buffer));
               compare_field("blocks_written", want.blocks_written, seen.blocks_written);
               compare_field("recording_done", word_type'(want.recording_done),
                             word_type'(seen.recording_done));
               compare_field("fewest_free",    word_type'(want.fewest_free),
                             word_type'(seen.fewest_free));
               compare_field("overrun_count",  want.overrun_count,  seen.overrun_count);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_FILE_LIMIT) file_capacity = csr_pwdata;
               else                                blocks_wanted = csr_pwdata;
            end else if (csr_paddr[2] == CSR_FILE_LIMIT) begin
               compare_field("file_block_limit", file_capacity, csr_prdata);
            end else begin
               compare_field("max_blocks", blocks_wanted, csr_prdata);
            end
         end
         if (req_valid && !req_stall) begin
            advance_period(req_card_busy, want);
            due_results.push_back(want);
         end
      end
      outstanding <= due_results.size();
   end

endmodule
`default_nettype wire

// File: dv/tb_sample_block_buffer_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sample_block_buffer_manager
// Stimulus and verdict for the sample block buffer manager.
//
// Drives sample periods with the card busy flag through a short directed
// opening and then phases shaped to fill the pool, starve it into overruns,
// drain it, and finally stop recording at a block limit. Both channels idle
// at random apart from two quiet stretches. The limit registers are written
// and read back between phases. All checking lives in sbbm_checker.
// ----------------------------------------------------------------------------
module tb_sample_block_buffer_manager;
   timeunit 1ns;
   timeprecision 1ps;
   import sbbm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic       req_card_busy = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_sample_taken;
   buf_type    rsp_sample_buffer;
   slot_type   rsp_sample_slot;
   logic       rsp_overrun;
   logic       rsp_write_issued;
   buf_type    rsp_write_buffer;
   word_type   rsp_blocks_written;
   logic       rsp_recording_done;
   count_type  rsp_fewest_free;
   word_type   rsp_overrun_count;
   logic       csr_psel      = 1'b0;
   logic       csr_penable   = 1'b0;
   logic       csr_pwrite    = 1'b0;
   logic [2:0] csr_paddr     = '0;
   word_type   csr_pwdata    = '0;
   word_type   csr_prdata;
   logic       csr_pready;

   int         error_count;
   int         outstanding;
   int         cycles        = 0;
   logic       quiet         = 1'b0;   // no idling on either side while set
   word_type   last_written  = '0;
   logic       done_seen     = 1'b0;

   sample_block_buffer_manager dut (.*);
   sbbm_checker                checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall with a chance of about 16 in a hundred on each edge unless quiet.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 16);
   end

   // Track progress from result transfers to steer the final limit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         last_written <= rsp_blocks_written;
         if (rsp_recording_done) done_seen <= 1'b1;
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Send one sample period; valid stays high into the next call, so it is
   // only lowered when a gap is drawn.
   task automatic send_period(input logic busy);
      while (!quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_card_busy <= busy;
      do @(posedge clock); while (req_stall);
   endtask

   // Send a run of periods, the card busy in busy_pct of a hundred.
   task automatic send_run(input int count, input int busy_pct);
      for (int i = 0; i < count; i++) send_period($urandom_range(0, 99) < busy_pct);
   endtask

   // Drop valid and hold until the checker reports every result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, then release the bus.
   task automatic csr_access(input logic wr, input logic idx, input word_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write both limits and read them back; the checker compares the reads.
   task automatic set_limits(input word_type wanted, input word_type capacity);
      csr_access(1'b1, CSR_MAX_BLOCKS, wanted);
      csr_access(1'b1, CSR_FILE_LIMIT, capacity);
      csr_access(1'b0, CSR_MAX_BLOCKS, '0);
      csr_access(1'b0, CSR_FILE_LIMIT, '0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Read the reset values, then open with no wanted-block limit and the
      // largest file capacity.
      csr_access(1'b0, CSR_MAX_BLOCKS, '0);
      csr_access(1'b0, CSR_FILE_LIMIT, '0);
      set_limits('0, COUNT_MAX);

      // Directed: card busy follows bit 2 XOR bit 0 of the period index, back to back.
      quiet <= 1'b1;
      for (int i = 0; i < 24; i++) send_period(i[2] ^ i[0]);
      quiet <= 1'b0;

      // Fill and write buffers at a moderate card load.
      send_run(200, 30);
      // Keep the card busy until every buffer sits in the full ring and
      // samples overrun.
      send_run(380, 100);
      // Card idle: drain the ring back onto the free stack.
      send_run(60, 0);
      drain();

      // Smallest file capacity, already passed, and the largest wanted
      // count: neither matches, recording goes on.
      set_limits(COUNT_MAX, 32'd1);
      quiet <= 1'b1;
      send_run(150, 25);
      quiet <= 1'b0;
      send_run(150, 25);
      send_run(200, 60);
      drain();

      // Stop a few blocks ahead via one limit or the other.
      if ($urandom_range(0, 1)) set_limits(last_written + 32'd6, COUNT_MAX);
      else                      set_limits('0, last_written + 32'd6);
      while (!done_seen) send_period($urandom_range(0, 99) < 20);
      // Periods after the stop must be ignored.
      send_run(40, 50);
      drain();

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
design/sbbm_pkg.sv
design/sample_block_buffer_manager.sv
dv/sbbm_checker.sv
dv/tb_sample_block_buffer_manager.sv
